FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent property helpers clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ftma_pkg.sv
// ---------------------------------------------------------------------------
// ftma_pkg
// shared constants and types of the frame time moving average
// ---------------------------------------------------------------------------
package ftma_pkg;

	// samples in the averaging window
	localparam int WINDOW = 120;

	localparam int SAMPLE_W = 20;
	localparam int RATE_W   = 32;
	localparam int IDX_W    = $clog2(WINDOW);

	// exact window sum never wraps
	localparam longint unsigned SUM_MAX = longint'(WINDOW) * ((64'd1 << SAMPLE_W) - 64'd1);
	localparam int SUM_W = $clog2(SUM_MAX + 64'd1);

	// rate dividend: WINDOW * 1e6 * 256
	localparam longint unsigned RATE_NUM = longint'(WINDOW) * 64'd256000000;
	localparam int NUM_W = $clog2(RATE_NUM + 64'd1);

	// reciprocal for the division by WINDOW: avg = (sum * AVG_MUL) >> AVG_SHIFT,
	// exact for every sum below 2**SUM_W
	localparam int WIN_W     = $clog2(WINDOW + 1);
	localparam int AVG_SHIFT = SUM_W + WIN_W;
	localparam longint unsigned AVG_MUL =
		((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam int AVG_MUL_W  = $clog2(AVG_MUL + 64'd1);
	localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

	// divider step counter
	localparam int CNT_W = $clog2(NUM_W + 1);

	typedef struct packed {
		logic                done;
		logic [SAMPLE_W-1:0] avg;
		logic [RATE_W-1:0]   rate;
	} ftma_div_res_t;

endpackage

FILE: hw/rtl/ftma_in_if.sv
// ---------------------------------------------------------------------------
// ftma_in_if
// frame duration channel, valid/ready
// ---------------------------------------------------------------------------
interface ftma_in_if;

	logic                          valid;
	logic                          ready;
	logic [ftma_pkg::SAMPLE_W-1:0] frame_time_us;

	modport source (output valid, output frame_time_us, input ready);
	modport sink   (input valid, input frame_time_us, output ready);

endinterface

FILE: hw/rtl/ftma_out_if.sv
// ---------------------------------------------------------------------------
// ftma_out_if
// average and frame rate channel, valid/ready
// ---------------------------------------------------------------------------
interface ftma_out_if;

	logic                          valid;
	logic                          ready;
	logic [ftma_pkg::SAMPLE_W-1:0] avg_frame_time_us;
	logic [ftma_pkg::RATE_W-1:0]   frames_per_second_q8;

	modport source (output valid, output avg_frame_time_us, output frames_per_second_q8,
		input ready);
	modport sink   (input valid, input avg_frame_time_us, input frames_per_second_q8,
		output ready);

endinterface

FILE: hw/rtl/frame_time_moving_average_top.sv
// ---------------------------------------------------------------------------
// frame_time_moving_average_top
// boxcar moving average of frame durations with frame rate in q.8
// ---------------------------------------------------------------------------
// usage:
//   frame  : sink channel, one frame duration in microseconds per transaction
//   stats  : source channel, one transaction per frame transaction, holding
//            the window average (us) and the frame rate times 256
//   an item passes from acceptance to a valid result through one update/write
//   step on the slot read at the accepting edge, the NUM_W steps of the
//   radix-2 rate divider and a load of the result register, which waits
//   while stats stalls
//   one item is in flight at a time; frame.ready is high only when idle, so a
//   new frame is taken only after the last result is loaded from the divider
//   the result register parts the channels: a new frame is taken while the
//   last result still waits; if stats stalls, the finished quotients are held
//   in the divider until the result register frees up
//   reset clears the write index, the window sum and the ring-filled flag;
//   ring slots not yet written read as zero until the index first wraps, so
//   no clearing pass over the ram is needed
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_time_moving_average_top (
	input  logic              clk,
	input  logic              arst_n,
	ftma_in_if.sink           frame,
	ftma_out_if.source        stats
);

	localparam int SAMPLE_W = ftma_pkg::SAMPLE_W;
	localparam int SUM_W    = ftma_pkg::SUM_W;
	localparam int IDX_W    = ftma_pkg::IDX_W;

	// sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]                  state_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        filled_q;
	logic [SUM_W-1:0]            sum_q;
	logic [SAMPLE_W-1:0]         sample_s1;

	logic                        out_valid_q;
	logic [SAMPLE_W-1:0]         avg_q;
	logic [ftma_pkg::RATE_W-1:0] rate_q;

	logic                        accept;
	logic                        update;
	logic                        wrap;
	logic                        load;
	logic                        out_free;
	logic [SAMPLE_W-1:0]         ram_rdata;
	logic [SAMPLE_W-1:0]         old_sample;
	logic [SUM_W-1:0]            sum_next;
	logic                        div_busy;
	ftma_pkg::ftma_div_res_t     div_res;

	assign frame.ready = (state_q == ST_IDLE);
	assign accept      = frame.valid && frame.ready;
	assign update      = (state_q == ST_READ);
	assign wrap        = (idx_q == IDX_W'(ftma_pkg::WINDOW - 1));
	assign out_free    = !out_valid_q || stats.ready;
	assign load        = out_free &&
		(((state_q == ST_DIV) && div_res.done) || (state_q == ST_HOLD));

	// slots not yet written since reset count as zero
	assign old_sample = filled_q ? ram_rdata : '0;
	assign sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_s1);

	// history ring: read the oldest slot on accept, overwrite it in the next cycle
	ftma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (ftma_pkg::WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (update),
		.waddr (idx_q),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	ftma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (update),
		.sum    (sum_next),
		.busy   (div_busy),
		.res    (div_res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= frame.frame_time_us;
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			filled_q <= 1'b0;
			sum_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					sum_q   <= sum_next;
					idx_q   <= wrap ? '0 : idx_q + 1'b1;
					if (wrap) begin
						filled_q <= 1'b1;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						state_q <= load ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			avg_q  <= div_res.avg;
			rate_q <= div_res.rate;
		end
	end

	assign stats.valid                = out_valid_q;
	assign stats.avg_frame_time_us    = avg_q;
	assign stats.frames_per_second_q8 = rate_q;

	// checks
	`ASSERT_NXT(a_accept_to_read, accept, state_q == ST_READ, "accept did not start a ram read")
	`ASSERT_IMP(a_done_in_div, div_res.done, state_q == ST_DIV, "divider finished out of sequence")
	`ASSERT_IMP(a_idle_div_quiet, state_q == ST_IDLE, !div_busy, "divider busy while idle")
	`ASSERT_NXT(a_wrap_fills, update && wrap, filled_q && (idx_q == '0), "ring wrap not recorded")

endmodule

FILE: hw/rtl/ftma_ram.sv
// ---------------------------------------------------------------------------
// ftma_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module ftma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/ftma_div.sv
// ---------------------------------------------------------------------------
// ftma_div
// radix-2 restoring divider for rate = RATE_NUM / sum, reciprocal multiply
// for avg = sum / WINDOW
// ---------------------------------------------------------------------------
module ftma_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ftma_pkg::SUM_W-1:0]  sum,
	output logic                        busy,
	output ftma_pkg::ftma_div_res_t     res
);

	localparam int SUM_W      = ftma_pkg::SUM_W;
	localparam int NUM_W      = ftma_pkg::NUM_W;
	localparam int CNT_W      = ftma_pkg::CNT_W;
	localparam int AVG_PROD_W = ftma_pkg::AVG_PROD_W;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 zero_q;
	logic [SUM_W-1:0]     divisor_q;
	// rate lane
	logic [NUM_W-1:0]     num_a_q;
	logic [SUM_W-1:0]     rem_a_q;
	logic [NUM_W-1:0]     quo_a_q;
	// average lane
	logic [ftma_pkg::SAMPLE_W-1:0] avg_q;

	logic [SUM_W:0]       sh_a;
	logic [SUM_W:0]       diff_a;
	logic                 ge_a;
	logic [AVG_PROD_W-1:0] avg_prod;
	logic [63:0]          quo_a_ext;

	always_comb begin
		sh_a     = {rem_a_q, num_a_q[NUM_W-1]};
		diff_a   = sh_a - {1'b0, divisor_q};
		ge_a     = (sh_a >= {1'b0, divisor_q});
		avg_prod = AVG_PROD_W'(divisor_q) * AVG_PROD_W'(ftma_pkg::AVG_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q    <= (sum == '0);
			divisor_q <= sum;
			num_a_q   <= NUM_W'(ftma_pkg::RATE_NUM);
			rem_a_q   <= '0;
			quo_a_q   <= '0;
		end else if (busy_q) begin
			num_a_q <= num_a_q << 1;
			rem_a_q <= ge_a ? diff_a[SUM_W-1:0] : sh_a[SUM_W-1:0];
			quo_a_q <= {quo_a_q[NUM_W-2:0], ge_a};
			avg_q   <= avg_prod[ftma_pkg::AVG_SHIFT +: ftma_pkg::SAMPLE_W];
		end
	end

	// saturate the rate to 32 bits, force zero for an empty window
	always_comb begin
		quo_a_ext = 64'(quo_a_q);
		res.done  = done_q;
		res.avg   = avg_q;
		if (zero_q) begin
			res.rate = '0;
		end else if (quo_a_ext > 64'h0000_0000_FFFF_FFFF) begin
			res.rate = '1;
		end else begin
			res.rate = quo_a_ext[ftma_pkg::RATE_W-1:0];
		end
	end

	assign busy = busy_q;

endmodule

FILE: tb/sv/frame_time_moving_average_top_test.sv
// ---------------------------------------------------------------------------
// frame_time_moving_average_top_test
// self-checking test of the frame time moving average: directed frame
// durations at the edges of the window math, then randomized phases that
// fill the ring at full scale, drain it back to empty and mix typical frame
// times, all checked against an in-bench boxcar average and rate predictor
// ---------------------------------------------------------------------------
module frame_time_moving_average_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import ftma_pkg::*;

	// one result transaction as seen on the stats channel
	typedef struct packed {
		logic [SAMPLE_W-1:0] avg;
		logic [RATE_W-1:0]   rate;
	} stats_t;

	// directed row: typed rows carry their own expected result
	typedef struct packed {
		logic [SAMPLE_W-1:0] frame_time_us;
		bit                  typed;
		stats_t              want;
	} directed_row_t;

	// shapes of the random frame stream
	typedef enum int {
		PH_MIX,
		PH_FULL_SCALE,
		PH_DRAIN,
		PH_TINY
	} frame_phase_t;

	localparam logic [RATE_W-1:0]   RATE_SAT    = '1;
	localparam logic [SAMPLE_W-1:0] FRAME_MAX   = '1;
	localparam int                  LATENCY     = NUM_W + 3;
	localparam int                  MAX_GAP     = 18;
	localparam int                  HOLD_OFF    = 400;
	localparam int                  HOLD_AT     = 30;
	localparam int                  STALL_LIMIT = 4000;
	localparam int                  MAX_REPORTS = 10;
	localparam int                  N_DIRECTED  = 16;

	// short directed part, results typed in only where they are obvious
	directed_row_t directed_rows [N_DIRECTED] = '{
		// empty window right after reset: rate and average both zero
		'{20'd0,       1'b1, '{20'd0, 32'd0}},
		// one microsecond in the window: rate saturates
		'{20'd1,       1'b1, '{20'd0, RATE_SAT}},
		// sum of seven still saturates
		'{20'd6,       1'b1, '{20'd0, RATE_SAT}},
		// sum of eight is the first one that fits: 120 * 256e6 / 8
		'{20'd1,       1'b1, '{20'd0, 32'd3840000000}},
		'{20'hFFFFF,   1'b0, '0},
		'{20'hAAAAA,   1'b0, '0},
		'{20'h55555,   1'b0, '0},
		'{20'h80000,   1'b0, '0},
		'{20'hFFFFE,   1'b0, '0},
		'{20'h7FFFF,   1'b0, '0},
		'{20'd16667,   1'b0, '0},
		'{20'd33333,   1'b0, '0},
		'{20'd8333,    1'b0, '0},
		'{20'd100000,  1'b0, '0},
		'{20'd1,       1'b0, '0},
		'{20'd0,       1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	ftma_in_if  frame_if ();
	ftma_out_if stats_if ();

	frame_time_moving_average_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_if),
		.stats  (stats_if)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: ring of past durations, next slot and exact sum
	logic [SAMPLE_W-1:0] ring_model [WINDOW];
	logic [IDX_W-1:0]    ring_slot;
	logic [SUM_W-1:0]    ring_sum;

	// expected results in arrival order
	stats_t stats_expect_q [$];

	int  frames_sent;
	int  results_seen;
	int  mismatches;
	int  empty_window_hits;
	int  saturated_rate_hits;
	int  full_scale_hits;
	bit  frame_quiet;
	bit  stats_quiet;
	bit  hold_off_done;
	int  stall_cycles;

	// store the new duration, retire the overwritten one, then divide
	function automatic stats_t average_and_rate(input logic [SAMPLE_W-1:0] sample);
		longint unsigned quotient;
		stats_t          r;
		ring_sum              = ring_sum - ring_model[ring_slot] + sample;
		ring_model[ring_slot] = sample;
		ring_slot             = (ring_slot == IDX_W'(WINDOW - 1)) ? '0 : ring_slot + 1'b1;
		r.avg = SAMPLE_W'(ring_sum / SUM_W'(WINDOW));
		if (ring_sum == '0) begin
			r.rate = '0;
		end else begin
			quotient = RATE_NUM / 64'(ring_sum);
			r.rate   = (quotient > 64'(RATE_SAT)) ? RATE_SAT : RATE_W'(quotient);
		end
		return r;
	endfunction

	// idle cycles before the next transaction; quiet stretches have none
	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_frame_time(input frame_phase_t phase);
		int roll;
		case (phase)
			PH_FULL_SCALE: begin
				return FRAME_MAX;
			end
			PH_DRAIN: begin
				return '0;
			end
			PH_TINY: begin
				return SAMPLE_W'($urandom_range(0, 3));
			end
			default: begin
				roll = $urandom_range(0, 9);
				if (roll <= 5)
					return SAMPLE_W'($urandom_range(4000, 70000));
				else if (roll <= 7)
					return SAMPLE_W'($urandom_range(0, 32'hFFFFF));
				else if (roll == 8)
					return SAMPLE_W'($urandom_range(0, 7));
				else
					return FRAME_MAX;
			end
		endcase
	endfunction

	function automatic void note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch on result %0d: %s expected %0d got %0d",
				results_seen, what, want, got);
	endfunction

	// offer one frame duration; prediction is made at the accepting edge
	task automatic offer_frame(input logic [SAMPLE_W-1:0] t, input bit typed,
			input stats_t want);
		int     gap;
		stats_t predicted;
		gap = draw_gap(frame_quiet);
		@(negedge clk);
		if (gap > 0) begin
			frame_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_if.valid         <= 1'b1;
		frame_if.frame_time_us <= t;
		do @(posedge clk); while (!frame_if.ready);
		// predictor always advances; typed rows override its answer
		predicted = average_and_rate(t);
		stats_expect_q.push_back(typed ? want : predicted);
		frames_sent++;
		// switch between idling and back-to-back stretches now and then
		if ($urandom_range(0, 29) == 0)
			frame_quiet = !frame_quiet;
	endtask

	task automatic run_phase(input frame_phase_t phase, input int count);
		repeat (count) offer_frame(pick_frame_time(phase), 1'b0, '0);
	endtask

	// stimulus and end of run
	initial begin
		frame_if.valid         = 1'b0;
		frame_if.frame_time_us = '0;
		arst_n                 = 1'b0;
		ring_slot              = '0;
		ring_sum               = '0;
		for (int i = 0; i < WINDOW; i++)
			ring_model[i] = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed rows first, ring still mostly cleared
		foreach (directed_rows[i])
			offer_frame(directed_rows[i].frame_time_us, directed_rows[i].typed,
				directed_rows[i].want);

		// random phases: mixed traffic, ring filled at full scale, drained back
		// to an empty window, tiny sums for rate saturation, then mixed again
		run_phase(PH_MIX, 120);
		run_phase(PH_FULL_SCALE, WINDOW);
		run_phase(PH_DRAIN, WINDOW);
		run_phase(PH_TINY, 20);
		run_phase(PH_MIX, 140);

		@(negedge clk);
		frame_if.valid <= 1'b0;

		// drain outstanding results; the watchdog covers a hang here
		while (stats_expect_q.size() != 0)
			@(posedge clk);
		// give a stray extra result time to show up
		repeat (2 * LATENCY) @(posedge clk);

		$display("covered %0d frames, %0d results: %0d empty, %0d saturated, %0d full scale",
			frames_sent, results_seen, empty_window_hits, saturated_rate_hits,
			full_scale_hits);
		$display("ring wrapped %0d times, one receiver hold-off of %0d cycles",
			frames_sent / WINDOW, HOLD_OFF);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result side: random ready stalls, one long hold-off to back up the block
	initial begin
		int     gap;
		stats_t got;
		stats_t want;
		stats_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(stats_quiet);
			if (!hold_off_done && results_seen == HOLD_AT) begin
				// sender keeps offering, so the result register and the divider
				// fill up and frame.ready has to drop
				gap           = HOLD_OFF;
				hold_off_done = 1'b1;
			end
			@(negedge clk);
			if (gap > 0) begin
				stats_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			stats_if.ready <= 1'b1;
			do @(posedge clk); while (!stats_if.valid);

			got.avg  = stats_if.avg_frame_time_us;
			got.rate = stats_if.frames_per_second_q8;
			if (stats_expect_q.size() == 0) begin
				note_mismatch("unexpected result, avg", '0, 64'(got.avg));
			end else begin
				want = stats_expect_q.pop_front();
				if (got.avg !== want.avg)
					note_mismatch("avg_frame_time_us", 64'(want.avg), 64'(got.avg));
				if (got.rate !== want.rate)
					note_mismatch("frames_per_second_q8", 64'(want.rate), 64'(got.rate));
			end
			results_seen++;
			if (got.rate == '0 && got.avg == '0)
				empty_window_hits++;
			if (got.rate == RATE_SAT)
				saturated_rate_hits++;
			if (got.avg == FRAME_MAX)
				full_scale_hits++;
			if ($urandom_range(0, 29) == 0)
				stats_quiet = !stats_quiet;
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (frame_if.valid && frame_if.ready) ||
				(stats_if.valid && stats_if.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles, %0d results pending",
					STALL_LIMIT, stats_expect_q.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule
